[rtl/dots_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dots_pkg: shared types and constants for the disk occupancy block
// Field widths, register indexes, controller states and the command and
// status bundles passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package dots_pkg;

  // Grid size defaults
  localparam int DEF_MAX_WIDTH  = 128;
  localparam int DEF_MAX_HEIGHT = 128;

  // Field and register widths
  localparam int PT_W  = 10;  // signed point coordinate
  localparam int CFG_W = 8;   // widest configuration register
  localparam int RAD_W = 4;   // radius register
  localparam int IDX_W = 2;   // configuration register index
  localparam int OFS_W = RAD_W + 1;  // signed offset -r..r
  localparam int CRD_W = PT_W + 1;   // signed cell coordinate

  // Register indexes
  localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] REG_RADIUS = 2'd2;

  // Register reset values
  localparam logic [CFG_W-1:0] RST_WIDTH  = 8'd128;
  localparam logic [CFG_W-1:0] RST_HEIGHT = 8'd128;
  localparam logic [RAD_W-1:0] RST_RADIUS = 4'd3;

  // Item opcodes
  localparam logic OPC_TEST  = 1'b0;
  localparam logic OPC_CLEAR = 1'b1;

  // Controller states
  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CHECK,
    ST_TEST,
    ST_TDRN1,
    ST_TDRN2,
    ST_DECIDE,
    ST_STAMP,
    ST_CLEAR,
    ST_RESP
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic ld_point;  // capture the point, drop the hit flag
    logic rst_cnt;   // restart the offset counters at -r
    logic scan_en;   // issue one cell and advance the counters
    logic stamp;     // issued cells are written, not read
    logic clr_en;    // write one zero of the clearing sweep
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic in_grid;    // captured point lies inside the grid
    logic scan_last;  // counters sit on the last cell of the square
    logic clr_last;   // sweep sits on the last memory entry
    logic hit;        // an occupied cell was found in the disk
  } dp_sts_t;

endpackage

[rtl/dots_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dots_if: item channels of the disk occupancy block
// Valid/ready channels for candidate items and for result items.
// ----------------------------------------------------------------------------
interface dots_in_if;
  logic                              valid;
  logic                              ready;
  logic                              opcode;
  logic signed [dots_pkg::PT_W-1:0]  point_x;
  logic signed [dots_pkg::PT_W-1:0]  point_y;

  modport source(output valid, output opcode, output point_x, output point_y, input ready);
  modport sink(input valid, input opcode, input point_x, input point_y, output ready);
endinterface

interface dots_out_if;
  logic valid;
  logic ready;
  logic accepted;

  modport source(output valid, output accepted, input ready);
  modport sink(input valid, input accepted, output ready);
endinterface

[rtl/dots_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dots_datapath: occupancy memory, scan counters and configuration
// Walks the square around the point one cell a cycle, reads or writes the
// one-bit occupancy memory, collects hits and runs the clearing sweep.
// ----------------------------------------------------------------------------
module dots_datapath #(
  parameter int MAX_WIDTH  = dots_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = dots_pkg::DEF_MAX_HEIGHT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [dots_pkg::IDX_W-1:0]        cfg_idx_i,
  input  logic [dots_pkg::CFG_W-1:0]        cfg_data_i,
  input  logic signed [dots_pkg::PT_W-1:0]  point_x_i,
  input  logic signed [dots_pkg::PT_W-1:0]  point_y_i,
  input  dots_pkg::dp_cmd_t                 cmd_i,
  output dots_pkg::dp_sts_t                 sts_o
);
  import dots_pkg::*;

  localparam int Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(Depth);
  localparam int WCap  = (MAX_WIDTH > 255) ? 255 : MAX_WIDTH;
  localparam int HCap  = (MAX_HEIGHT > 255) ? 255 : MAX_HEIGHT;
  localparam int SumW  = 2 * CFG_W + 1;
  localparam int D2W   = 2 * OFS_W + 1;

  logic [CFG_W-1:0]        gw_q, gh_q;
  logic [RAD_W-1:0]        rad_q;
  logic [CFG_W-1:0]        w_eff, h_eff;
  logic signed [PT_W-1:0]  px_q, py_q;
  logic signed [OFS_W-1:0] dx_q, dy_q, neg_r, pos_r;
  logic signed [CRD_W-1:0] cx, cy;
  logic                    cx_in, cy_in, disk_in;
  logic signed [2*OFS_W-1:0] dxx, dyy;
  logic [D2W-1:0]          d2;
  logic [2*RAD_W-1:0]      r2;
  logic [2*CFG_W-1:0]      row_base;
  logic [SumW-1:0]         lin_sum;
  logic                    acc_vld_q, acc_wr_q;
  logic [AW-1:0]           acc_addr_q;
  logic                    rd_vld_q, rd_q, hit_q;
  logic [AW-1:0]           clr_cnt_q;
  logic                    clr_last;
  logic                    mem_we, mem_wdata;
  logic [AW-1:0]           mem_waddr;
  logic                    mem [Depth];

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_q  <= RST_WIDTH;
      gh_q  <= RST_HEIGHT;
      rad_q <= RST_RADIUS;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WIDTH:  gw_q  <= cfg_data_i;
        REG_HEIGHT: gh_q  <= cfg_data_i;
        REG_RADIUS: rad_q <= cfg_data_i[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate the grid to the memory size
  assign w_eff = (gw_q > CFG_W'(WCap)) ? CFG_W'(WCap) : gw_q;
  assign h_eff = (gh_q > CFG_W'(HCap)) ? CFG_W'(HCap) : gh_q;

  // Capture the candidate point
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_point) begin
      px_q <= point_x_i;
      py_q <= point_y_i;
    end
  end

  assign sts_o.in_grid = !px_q[PT_W-1] && ($unsigned(px_q) < PT_W'(w_eff)) &&
                         !py_q[PT_W-1] && ($unsigned(py_q) < PT_W'(h_eff));

  // Offset counters, column first, over -r..r
  assign pos_r = $signed({1'b0, rad_q});
  assign neg_r = -pos_r;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dx_q <= '0;
      dy_q <= '0;
    end else if (cmd_i.rst_cnt) begin
      dx_q <= neg_r;
      dy_q <= neg_r;
    end else if (cmd_i.scan_en) begin
      if (dx_q == pos_r) begin
        dx_q <= neg_r;
        dy_q <= dy_q + OFS_W'(1);
      end else begin
        dx_q <= dx_q + OFS_W'(1);
      end
    end
  end

  assign sts_o.scan_last = (dx_q == pos_r) && (dy_q == pos_r);

  // Cell position, grid bounds and disk test
  assign cx    = CRD_W'(px_q) + CRD_W'(dx_q);
  assign cy    = CRD_W'(py_q) + CRD_W'(dy_q);
  assign cx_in = !cx[CRD_W-1] && ($unsigned(cx) < CRD_W'(w_eff));
  assign cy_in = !cy[CRD_W-1] && ($unsigned(cy) < CRD_W'(h_eff));

  assign dxx     = dx_q * dx_q;
  assign dyy     = dy_q * dy_q;
  assign d2      = D2W'($unsigned(dxx)) + D2W'($unsigned(dyy));
  assign r2      = rad_q * rad_q;
  assign disk_in = d2 < D2W'(r2);

  // Linear address at the current width
  assign row_base = cy[CFG_W-1:0] * w_eff;
  assign lin_sum  = SumW'(row_base) + SumW'(cx[CFG_W-1:0]);

  // Register the cell access
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_vld_q <= 1'b0;
      acc_wr_q  <= 1'b0;
    end else begin
      acc_vld_q <= cmd_i.scan_en && cx_in && cy_in && disk_in;
      acc_wr_q  <= cmd_i.stamp;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_addr_q <= AW'(lin_sum);
  end

  // Clearing sweep, one entry a cycle
  assign clr_last       = (clr_cnt_q == AW'(Depth - 1));
  assign sts_o.clr_last = clr_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_en) begin
      clr_cnt_q <= clr_last ? '0 : clr_cnt_q + AW'(1);
    end
  end

  // Occupancy memory
  assign mem_we    = cmd_i.clr_en || (acc_vld_q && acc_wr_q);
  assign mem_waddr = cmd_i.clr_en ? clr_cnt_q : acc_addr_q;
  assign mem_wdata = !cmd_i.clr_en;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[acc_addr_q];
  end

  // Collect hits from the read stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
      hit_q    <= 1'b0;
    end else begin
      rd_vld_q <= acc_vld_q && !acc_wr_q;
      if (cmd_i.ld_point) begin
        hit_q <= 1'b0;
      end else if (rd_vld_q && rd_q) begin
        hit_q <= 1'b1;
      end
    end
  end

  assign sts_o.hit = hit_q;

endmodule

[rtl/dots_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dots_ctrl: sequencer of the disk occupancy block
// Runs the reset sweep, the test scan, the stamp scan and the clear sweep,
// and holds the result register on the output channel.
// ----------------------------------------------------------------------------
module dots_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               opcode_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               accepted_o,
  output dots_pkg::dp_cmd_t  cmd_o,
  input  dots_pkg::dp_sts_t  sts_i
);
  import dots_pkg::*;

  state_e state_q, state_d;
  logic   res_q, res_d;
  logic   out_valid_q, accepted_q;
  logic   out_load;

  // State and pending result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      res_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    res_d      = res_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      ST_INIT: begin
        cmd_o.clr_en = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.ld_point = 1'b1;
          cmd_o.rst_cnt  = 1'b1;
          state_d = (opcode_i == OPC_CLEAR) ? ST_CLEAR : ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts_i.in_grid) begin
          state_d = ST_TEST;
        end else begin
          res_d   = 1'b0;
          state_d = ST_RESP;
        end
      end
      ST_TEST: begin
        cmd_o.scan_en = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_TDRN1;
        end
      end
      ST_TDRN1: state_d = ST_TDRN2;
      ST_TDRN2: state_d = ST_DECIDE;
      ST_DECIDE: begin
        if (sts_i.hit) begin
          res_d   = 1'b0;
          state_d = ST_RESP;
        end else begin
          cmd_o.rst_cnt = 1'b1;
          state_d       = ST_STAMP;
        end
      end
      ST_STAMP: begin
        cmd_o.scan_en = 1'b1;
        cmd_o.stamp   = 1'b1;
        if (sts_i.scan_last) begin
          res_d   = 1'b1;
          state_d = ST_RESP;
        end
      end
      ST_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (sts_i.clr_last) begin
          res_d   = 1'b0;
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output register: load a result, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_load || (out_valid_q && !out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      accepted_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign accepted_o  = accepted_q;

endmodule

[rtl/disk_occupancy_test_and_stamp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// disk_occupancy_test_and_stamp: occupancy grid test-and-stamp engine
// Tests a candidate point against a one-bit occupancy grid and stamps its
// disk when no occupied cell lies within the exclusion radius.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one item: opcode, point_x, point_y. Opcode test checks the
//   point and stamps its disk if in grid and free; clear empties the grid.
//   out_o carries one result per item: accepted.
//   Configuration (width, height, radius) is written through cfg_we_i,
//   cfg_idx_i, cfg_data_i while no item is in flight.
// Operation (N = (2r+1)^2 cells, one memory access per cycle):
//   point outside the grid: no scan, result not accepted;
//   collision found: one test scan of the N cells; stamped point: a
//   test scan and then a stamp scan, each cell of the square visited twice.
//   Clear item: one zero written to each of the MAX_WIDTH * MAX_HEIGHT entries.
//   One item at a time: in_i.ready is high only when the engine is idle.
// Reset runs the same clearing pass with in_i.ready low; configuration
// writes are taken during it.
// A finished result waits in the output register while out_o.ready is low;
// the next item is still taken, and its result waits until the slot frees.
// ----------------------------------------------------------------------------
module disk_occupancy_test_and_stamp #(
  parameter int MAX_WIDTH  = dots_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = dots_pkg::DEF_MAX_HEIGHT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  dots_in_if.sink                     in_i,
  dots_out_if.source                  out_o,
  input  logic                        cfg_we_i,
  input  logic [dots_pkg::IDX_W-1:0]  cfg_idx_i,
  input  logic [dots_pkg::CFG_W-1:0]  cfg_data_i
);
  import dots_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencer
  dots_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .opcode_i    (in_i.opcode),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .accepted_o  (out_o.accepted),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // Grid memory and scan datapath
  dots_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .point_x_i  (in_i.point_x),
    .point_y_i  (in_i.point_y),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

endmodule

[rtl/dots_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dots_checker: port-level checks for the disk occupancy block
// Watches the item channels and flags sequencing and handshake errors.
// ----------------------------------------------------------------------------
module dots_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic accepted_i
);

  // Engine takes one item at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("item taken while previous item still in work");

  // No result appears in the cycle right after an item is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !$rose(out_valid_i))
    else $error("result appeared too early");

  // Held result stays valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("result dropped while stalled");

  // Held result keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> $stable(accepted_i))
    else $error("result changed while stalled");

endmodule

bind disk_occupancy_test_and_stamp dots_checker u_dots_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .accepted_i  (out_o.accepted)
);

[test/disk_occupancy_test_and_stamp_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// disk_occupancy_test_and_stamp_test: test bench for the occupancy grid engine
// Drives candidate points and clear items through the valid/ready channels,
// keeps its own copy of the occupancy grid and registers, and compares each
// verdict with the predicted one. Covers the reset defaults, geometry edge
// cases, output back-pressure and long random runs over many settings.
// ----------------------------------------------------------------------------
module disk_occupancy_test_and_stamp_test;
  import dots_pkg::*;

  localparam int              MAX_W         = DEF_MAX_WIDTH;
  localparam int              MAX_H         = DEF_MAX_HEIGHT;
  localparam int              GRID_CELLS    = MAX_W * MAX_H;
  localparam logic [IDX_W-1:0] REG_STRAY    = 2'd3;  // unmapped register index
  localparam int              RANDOM_ITEMS  = 1500;
  localparam int              MAX_REPORTS   = 10;
  localparam longint          TIMEOUT_NS    = 40_000_000;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [IDX_W-1:0]    cfg_idx_i;
  logic [CFG_W-1:0]    cfg_data_i;

  dots_in_if  in_if ();
  dots_out_if out_if ();

  disk_occupancy_test_and_stamp u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // Shadow grid and registers
  bit               occ_grid [GRID_CELLS];
  logic [CFG_W-1:0] grid_cols  = RST_WIDTH;
  logic [CFG_W-1:0] grid_rows  = RST_HEIGHT;
  logic [RAD_W-1:0] excl_radius = RST_RADIUS;

  bit   verdict_q [$];    // predicted accepted bits, oldest first
  int   err_count       = 0;
  int   hold_off_cycles = 0;
  bit   gaps_on         = 1'b1;
  int   random_sent     = 0;

  function automatic int cols_in_use();
    return (grid_cols > MAX_W) ? MAX_W : int'(grid_cols);
  endfunction

  function automatic int rows_in_use();
    return (grid_rows > MAX_H) ? MAX_H : int'(grid_rows);
  endfunction

  // Walk the disk around a point: mark its cells, or report an occupied one
  function automatic bit sweep_disk(input int px, input int py, input bit mark);
    int w;
    int h;
    int r;
    int cx;
    int cy;
    w = cols_in_use();
    h = rows_in_use();
    r = int'(excl_radius);
    for (int dx = -r; dx <= r; dx++) begin
      for (int dy = -r; dy <= r; dy++) begin
        cx = px + dx;
        cy = py + dy;
        if (cx < 0 || cx >= w || cy < 0 || cy >= h) continue;
        if (dx * dx + dy * dy >= r * r) continue;
        if (mark) occ_grid[cx + cy * w] = 1'b1;
        else if (occ_grid[cx + cy * w]) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Advance the shadow grid by one item and return its verdict
  function automatic bit predict_verdict(input logic opc, input int px, input int py);
    if (opc == OPC_CLEAR) begin
      foreach (occ_grid[i]) occ_grid[i] = 1'b0;
      return 1'b0;
    end
    if (px < 0 || px >= cols_in_use() || py < 0 || py >= rows_in_use()) return 1'b0;
    if (sweep_disk(px, py, 1'b0)) return 1'b0;
    void'(sweep_disk(px, py, 1'b1));
    return 1'b1;
  endfunction

  task automatic note_error(input string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("%s", msg);
  endtask

  // Offer one item, hold it until taken, then record its verdict
  task automatic send_item(input logic opc, input logic signed [PT_W-1:0] px,
                           input logic signed [PT_W-1:0] py);
    if (gaps_on && $urandom_range(99) < 17) begin
      in_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 17);
    end
    in_if.valid   <= 1'b1;
    in_if.opcode  <= opc;
    in_if.point_x <= px;
    in_if.point_y <= py;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    verdict_q.push_back(predict_verdict(opc, int'(px), int'(py)));
  endtask

  // Stop offering and wait until every verdict is back
  task automatic drain();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (verdict_q.size() != 0);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      REG_WIDTH:  grid_cols   = data;
      REG_HEIGHT: grid_rows   = data;
      REG_RADIUS: excl_radius = data[RAD_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_geometry(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                              input logic [CFG_W-1:0] r);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_RADIUS, r);
    cfg_we_i <= 1'b0;
  endtask

  // Defaults after reset: corners, out-of-grid extremes, exact spacing, clear
  task automatic test_reset_defaults();
    send_item(OPC_TEST, 10'sd0, 10'sd0);
    send_item(OPC_TEST, 10'sd0, 10'sd0);
    send_item(OPC_TEST, 10'sd3, 10'sd0);
    send_item(OPC_TEST, 10'sd5, 10'sd0);
    send_item(OPC_TEST, 10'sd127, 10'sd127);
    send_item(OPC_TEST, 10'sd128, 10'sd5);
    send_item(OPC_TEST, -10'sd1, 10'sd10);
    send_item(OPC_TEST, -10'sd512, 10'sd511);
    send_item(OPC_TEST, 10'sd511, -10'sd512);
    send_item(OPC_CLEAR, -10'sd1, 10'sd511);
    send_item(OPC_TEST, 10'sd0, 10'sd0);
    drain();
  endtask

  // Saturated, empty and single-cell grids, radius extremes, remapped stamps
  task automatic test_geometry_edges();
    set_geometry(8'd200, 8'd255, 8'hF2);
    send_item(OPC_CLEAR, 10'sd0, 10'sd0);
    send_item(OPC_TEST, 10'sd127, 10'sd127);
    send_item(OPC_TEST, 10'sd128, 10'sd0);
    send_item(OPC_TEST, 10'sd127, 10'sd128);
    drain();
    set_geometry(8'd0, 8'd128, 8'd3);
    send_item(OPC_TEST, 10'sd0, 10'sd0);
    drain();
    set_geometry(8'd5, 8'd0, 8'd3);
    send_item(OPC_TEST, 10'sd0, 10'sd0);
    drain();
    set_geometry(8'd1, 8'd1, 8'd0);
    send_item(OPC_TEST, 10'sd0, 10'sd0);
    send_item(OPC_TEST, 10'sd0, 10'sd0);
    drain();
    // unmapped index must leave the single-cell grid alone
    write_reg(REG_STRAY, 8'd0);
    cfg_we_i <= 1'b0;
    send_item(OPC_TEST, 10'sd0, 10'sd0);
    drain();
    set_geometry(8'd128, 8'd128, 8'hFF);
    send_item(OPC_CLEAR, 10'sd0, 10'sd0);
    send_item(OPC_TEST, 10'sd64, 10'sd64);
    send_item(OPC_TEST, 10'sd80, 10'sd64);
    send_item(OPC_TEST, 10'sd94, 10'sd64);
    drain();
    // stamps keep linear addresses when the width changes
    set_geometry(8'd128, 8'd128, 8'd2);
    send_item(OPC_TEST, 10'sd20, 10'sd2);
    drain();
    set_geometry(8'd16, 8'd128, 8'd2);
    send_item(OPC_TEST, 10'sd4, 10'sd17);
    drain();
  endtask

  // Hold the result side off so the engine backs up into the input
  task automatic test_backpressure();
    set_geometry(8'd32, 8'd32, 8'd1);
    hold_off_cycles = 300;
    for (int i = 0; i < 6; i++) begin
      send_item(OPC_TEST, PT_W'($urandom_range(31)), PT_W'($urandom_range(31)));
    end
    drain();
  endtask

  // One setting of the registers, then a run of mostly well-formed points
  task automatic test_random_phase(input int n_items, input bit no_gaps);
    logic [CFG_W-1:0]          w;
    logic [CFG_W-1:0]          h;
    logic [CFG_W-1:0]          r;
    logic signed [PT_W-1:0]    px;
    logic signed [PT_W-1:0]    py;
    int                        kind;
    int                        we;
    int                        he;
    int                        n;
    gaps_on = !no_gaps;
    kind = $urandom_range(99);
    w = (kind < 70) ? CFG_W'($urandom_range(1, 48)) : (kind < 85) ? 8'd128 :
        (kind < 95) ? CFG_W'($urandom_range(129, 255)) : 8'd0;
    kind = $urandom_range(99);
    h = (kind < 70) ? CFG_W'($urandom_range(1, 48)) : (kind < 85) ? 8'd128 :
        (kind < 95) ? CFG_W'($urandom_range(129, 255)) : 8'd0;
    r = ($urandom_range(9) == 0) ? CFG_W'($urandom_range(6, 15)) : CFG_W'($urandom_range(5));
    r[CFG_W-1:RAD_W] = ($urandom_range(3) == 0) ? RAD_W'($urandom) : '0;
    set_geometry(w, h, r);
    we = cols_in_use();
    he = rows_in_use();
    // wide disks make each item slow: keep those runs short
    n = (r[RAD_W-1:0] > 5) ? n_items / 6 : n_items;
    if ($urandom_range(1)) send_item(OPC_CLEAR, PT_W'($urandom), PT_W'($urandom));
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(99);
      px = PT_W'($urandom);
      py = PT_W'($urandom);
      if (kind < 80 && we > 0 && he > 0) begin
        px = PT_W'($urandom_range(we - 1));
        py = PT_W'($urandom_range(he - 1));
      end else if (kind < 90) begin
        px = PT_W'(int'($urandom_range(3)) - 2 + ($urandom_range(1) ? we : 0));
        py = (he > 0 && $urandom_range(1)) ? PT_W'($urandom_range(he - 1)) :
             PT_W'(int'($urandom_range(3)) - 2 + ($urandom_range(1) ? he : 0));
      end
      send_item((kind == 99) ? OPC_CLEAR : OPC_TEST, px, py);
      random_sent++;
      if ($urandom_range(99) == 0) drain();
    end
    drain();
    gaps_on = 1'b1;
  endtask

  // Result side ready: random gaps, or a counted hold-off when asked
  initial begin : drive_result_ready
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_cycles > 0) begin
        hold_off_cycles--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= !(gaps_on && $urandom_range(99) < 17);
      end
    end
  end

  // Compare each taken verdict with the oldest prediction
  always @(posedge clk_i) begin : check_verdicts
    bit want;
    if (rst_ni === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (verdict_q.size() == 0) begin
        note_error($sformatf("unexpected result: accepted=%b", out_if.accepted));
      end else begin
        want = verdict_q.pop_front();
        if (out_if.accepted !== want)
          note_error($sformatf("mismatch on accepted: expected %b, got %b",
                               want, out_if.accepted));
      end
    end
  end

  // Main sequence
  initial begin : run_tests
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= REG_WIDTH;
    cfg_data_i    <= '0;
    in_if.valid   <= 1'b0;
    in_if.opcode  <= OPC_TEST;
    in_if.point_x <= '0;
    in_if.point_y <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_defaults();
    test_geometry_edges();
    test_backpressure();
    test_random_phase(200, 1'b1);
    while (random_sent < RANDOM_ITEMS) test_random_phase(150, 1'b0);
    drain();
    repeat (40) @(posedge clk_i);
    if (verdict_q.size() != 0)
      note_error($sformatf("%0d results never arrived", verdict_q.size()));
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Hard stop
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Verification failed");
    $finish;
  end

endmodule
